FILE: design/tic_pkg.sv
// ============================================================================
// tic_pkg
// Shared types, register map and helpers for the timer and interrupt block.
// ============================================================================
package tic_pkg;

    // Largest number of timers and external lines the block supports
    localparam int MAX_TIMERS    = 3;
    localparam int MAX_EXT_LINES = 3;

    // Request kinds
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_ACK   = 2'd3
    } t_mode;

    // Input request
    typedef struct packed {
        t_mode       mode;
        logic [8:0]  reg_offset;
        logic [15:0] write_data;
        logic [1:0]  byte_enable;
        logic [1:0]  ext_line;
        logic [2:0]  ack_level;
    } t_in_req;

    // Result
    typedef struct packed {
        logic [7:0]             irq_levels;
        logic [7:0]             ack_vector;
        logic [MAX_TIMERS-1:0]  timer_fired;
        logic                   zero_period_error;
    } t_out_req;

    // Word offsets of the decoded registers
    localparam logic [8:0] OFF_EXT_LVL   = 9'h040;  // one per external line
    localparam logic [8:0] OFF_TMR_LVL   = 9'h047;  // one per timer
    localparam logic [8:0] OFF_INT_MASK  = 9'h04a;
    localparam logic [8:0] OFF_VEC_BASE  = 9'h04d;
    localparam logic [2:0] OFF_TMR_PAGE  = 3'b100;  // offset[8:6] of timer window
    localparam logic [3:0] SUB_TMR_CTRL  = 4'h0;
    localparam logic [3:0] SUB_LIMIT_ONE = 4'h2;
    localparam logic [3:0] SUB_LIMIT_TWO = 4'h3;

    // Timer control fields
    localparam int TC_STOP_BIT    = 1;
    localparam int TC_INT_EN_BIT  = 2;
    localparam int TC_REPEAT_BIT  = 7;
    localparam int TC_LIMSEL_LSB  = 4;   // 2 bits
    localparam int TC_PRESC_LSB   = 10;  // 4 bits
    localparam int TC_CLKSRC_LSB  = 14;  // 2 bits
    localparam logic [1:0] LIMSEL_ONE   = 2'd1;
    localparam logic [1:0] LIMSEL_TWO   = 2'd2;
    localparam logic [1:0] CLKSRC_SYS   = 2'd0;
    localparam logic [3:0] PRESC_MAX    = 4'd8;

    // int_mask: line n at bit n, timer n at bit TMR_MASK_LSB + n
    localparam int TMR_MASK_LSB = 8;
    // Vector offset of timer 0 within the vector block
    localparam int TMR_VEC_OFS  = 4;

    // Byte-masked register update
    function automatic logic [15:0] merge_bytes(input logic [15:0] old_val,
                                                input logic [15:0] data,
                                                input logic [1:0]  be);
        logic [15:0] m;
        m = {{8{be[1]}}, {8{be[0]}}};
        return (old_val & ~m) | (data & m);
    endfunction

    // Timer period in ticks: selected limit << min(prescale, 8); zero for a
    // source other than the system clock or when no limit is selected
    function automatic logic [23:0] timer_period(input logic [15:0] ctrl,
                                                 input logic [15:0] lim_one,
                                                 input logic [15:0] lim_two);
        logic [23:0] lim;
        logic [3:0]  sc;
        logic [1:0]  sel;
        sel = ctrl[TC_LIMSEL_LSB +: 2];
        sc  = ctrl[TC_PRESC_LSB +: 4];
        lim = '0;
        if (sel == LIMSEL_ONE) begin
            lim = {8'h00, lim_one};
        end else if (sel == LIMSEL_TWO) begin
            lim = {8'h00, lim_two};
        end
        if (sc > PRESC_MAX) begin
            sc = PRESC_MAX;
        end
        if (ctrl[TC_CLKSRC_LSB +: 2] != CLKSRC_SYS) begin
            return '0;
        end
        return lim << sc;
    endfunction

endpackage

FILE: design/timer_interrupt_controller_top.sv
// ============================================================================
// timer_interrupt_controller_top
// Programmable timers plus an eight-level interrupt controller.
// ============================================================================
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | to block  | i_in_valid / o_in_stall | i_in  (tic_pkg::t_in_req)
//  out     | from block| o_out_valid / i_out_stall| o_out (tic_pkg::t_out_req)
//
//  One request per clock while the result side does not stall, and one result
//  per request: request register, then one pass of decode / timer / interrupt
//  logic into the result register. The rate is set by that single pass.
//  i_rst_n (synchronous, active low) clears every state register and timer and
//  empties both stages. A stall on the result side holds the result
//  register and, once the request register is also full, stalls the input.
//
module timer_interrupt_controller_top #(
    parameter int TIMER_COUNT = tic_pkg::MAX_TIMERS,
    parameter int EXT_LINES   = tic_pkg::MAX_EXT_LINES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tic_pkg::t_in_req  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tic_pkg::t_out_req o_out
);
    import tic_pkg::*;

    // ---------------- pipeline registers ----------------
    logic     r_in_valid;
    t_in_req  r_in;
    logic     r_out_valid;
    t_out_req r_out;
    t_out_req n_out;

    // ---------------- architectural state ----------------
    logic [15:0] r_ext_lvl  [EXT_LINES];
    logic [15:0] n_ext_lvl  [EXT_LINES];
    logic [15:0] r_tmr_lvl  [TIMER_COUNT];
    logic [15:0] n_tmr_lvl  [TIMER_COUNT];
    logic [15:0] r_tmr_ctrl [TIMER_COUNT];
    logic [15:0] n_tmr_ctrl [TIMER_COUNT];
    logic [15:0] r_lim_one  [TIMER_COUNT];
    logic [15:0] n_lim_one  [TIMER_COUNT];
    logic [15:0] r_lim_two  [TIMER_COUNT];
    logic [15:0] n_lim_two  [TIMER_COUNT];
    logic [23:0] r_tmr_cnt  [TIMER_COUNT];   // zero means stopped
    logic [23:0] n_tmr_cnt  [TIMER_COUNT];
    logic [15:0] r_int_mask;
    logic [15:0] n_int_mask;
    logic [15:0] r_vec_base;
    logic [15:0] n_vec_base;
    logic [EXT_LINES-1:0] r_pending;
    logic [EXT_LINES-1:0] n_pending;
    logic [7:0]  r_lvl_vec  [8];
    logic [7:0]  n_lvl_vec  [8];
    logic [7:0]  r_held;
    logic [7:0]  n_held;

    // ---------------- flow control ----------------
    logic out_ready;   // result register can take a new result
    logic advance;     // request in stage one is processed this cycle

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_ready;
    assign o_in_stall  = r_in_valid && !out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // ---------------- single-pass request logic ----------------
    always_comb begin
        logic [23:0] cnt_dec;
        logic [23:0] period;
        logic [2:0]  lvl;
        logic        line_hit;
        logic        err;
        logic [MAX_TIMERS-1:0] fired;
        logic [7:0]  ack_vec;

        n_ext_lvl  = r_ext_lvl;
        n_tmr_lvl  = r_tmr_lvl;
        n_tmr_ctrl = r_tmr_ctrl;
        n_lim_one  = r_lim_one;
        n_lim_two  = r_lim_two;
        n_tmr_cnt  = r_tmr_cnt;
        n_int_mask = r_int_mask;
        n_vec_base = r_vec_base;
        n_pending  = r_pending;
        n_lvl_vec  = r_lvl_vec;
        n_held     = r_held;
        cnt_dec    = '0;
        period     = '0;
        lvl        = '0;
        line_hit   = 1'b0;
        err        = 1'b0;
        fired      = '0;
        ack_vec    = '0;

        unique case (r_in.mode)
            MODE_WRITE: begin
                if (r_in.byte_enable != 2'b00) begin
                    for (int e = 0; e < EXT_LINES; e++) begin
                        if (r_in.reg_offset == OFF_EXT_LVL + 9'(e)) begin
                            n_ext_lvl[e] = merge_bytes(r_ext_lvl[e], r_in.write_data,
                                                       r_in.byte_enable);
                        end
                    end
                    for (int t = 0; t < TIMER_COUNT; t++) begin
                        if (r_in.reg_offset == OFF_TMR_LVL + 9'(t)) begin
                            n_tmr_lvl[t] = merge_bytes(r_tmr_lvl[t], r_in.write_data,
                                                       r_in.byte_enable);
                        end
                    end
                    if (r_in.reg_offset == OFF_INT_MASK) begin
                        n_int_mask = merge_bytes(r_int_mask, r_in.write_data,
                                                 r_in.byte_enable);
                    end
                    if (r_in.reg_offset == OFF_VEC_BASE) begin
                        n_vec_base = merge_bytes(r_vec_base, r_in.write_data,
                                                 r_in.byte_enable);
                    end
                    for (int t = 0; t < TIMER_COUNT; t++) begin
                        if (r_in.reg_offset[8:4] == {OFF_TMR_PAGE, 2'(t)}) begin
                            if (r_in.reg_offset[3:0] == SUB_TMR_CTRL) begin
                                n_tmr_ctrl[t] = merge_bytes(r_tmr_ctrl[t],
                                                            r_in.write_data,
                                                            r_in.byte_enable);
                                // low-byte write restarts the timer
                                if (r_in.byte_enable[0]) begin
                                    n_tmr_cnt[t] = '0;
                                    if (!n_tmr_ctrl[t][TC_STOP_BIT]) begin
                                        period = timer_period(n_tmr_ctrl[t],
                                                              r_lim_one[t], r_lim_two[t]);
                                        if (period == '0) begin
                                            err = 1'b1;
                                        end else begin
                                            n_tmr_cnt[t] = period;
                                        end
                                    end
                                end
                            end else if (r_in.reg_offset[3:0] == SUB_LIMIT_ONE) begin
                                n_lim_one[t] = merge_bytes(r_lim_one[t], r_in.write_data,
                                                           r_in.byte_enable);
                            end else if (r_in.reg_offset[3:0] == SUB_LIMIT_TWO) begin
                                n_lim_two[t] = merge_bytes(r_lim_two[t], r_in.write_data,
                                                           r_in.byte_enable);
                            end
                        end
                    end
                end
            end
            MODE_EDGE: begin
                for (int e = 0; e < EXT_LINES; e++) begin
                    if (r_in.ext_line == 2'(e)) begin
                        n_pending[e] = 1'b1;
                        line_hit     = 1'b1;
                    end
                end
                // all unmasked pending lines are served; later lines win a level
                if (line_hit) begin
                    for (int e = 0; e < EXT_LINES; e++) begin
                        if (n_pending[e] && !r_int_mask[e]) begin
                            lvl            = r_ext_lvl[e][2:0];
                            n_lvl_vec[lvl] = {r_vec_base[7:5], 5'(e)};
                            n_held[lvl]    = 1'b1;
                            n_pending[e]   = 1'b0;
                        end
                    end
                end
            end
            MODE_TICK: begin
                for (int t = 0; t < TIMER_COUNT; t++) begin
                    if (r_tmr_cnt[t] != '0) begin
                        cnt_dec      = r_tmr_cnt[t] - 24'd1;
                        n_tmr_cnt[t] = cnt_dec;
                        if (cnt_dec == '0) begin
                            fired[t] = 1'b1;
                            if (r_tmr_ctrl[t][TC_INT_EN_BIT] &&
                                !r_int_mask[TMR_MASK_LSB + t]) begin
                                lvl            = r_tmr_lvl[t][2:0];
                                n_lvl_vec[lvl] = {r_vec_base[7:5], 5'(TMR_VEC_OFS + t)};
                                n_held[lvl]    = 1'b1;
                            end
                            // repeat: reload from the current registers
                            if (r_tmr_ctrl[t][TC_REPEAT_BIT] &&
                                !r_tmr_ctrl[t][TC_STOP_BIT]) begin
                                period = timer_period(r_tmr_ctrl[t],
                                                      r_lim_one[t], r_lim_two[t]);
                                if (period == '0) begin
                                    err = 1'b1;
                                end else begin
                                    n_tmr_cnt[t] = period;
                                end
                            end
                        end
                    end
                end
            end
            MODE_ACK: begin
                ack_vec                 = r_lvl_vec[r_in.ack_level];
                n_held[r_in.ack_level]  = 1'b0;
            end
            default: begin
            end
        endcase

        n_out.irq_levels        = n_held;
        n_out.ack_vector        = ack_vec;
        n_out.timer_fired       = fired;
        n_out.zero_period_error = err;
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < EXT_LINES; e++) begin
                r_ext_lvl[e] <= '0;
            end
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_tmr_lvl[t]  <= '0;
                r_tmr_ctrl[t] <= '0;
                r_lim_one[t]  <= '0;
                r_lim_two[t]  <= '0;
                r_tmr_cnt[t]  <= '0;
            end
            for (int l = 0; l < 8; l++) begin
                r_lvl_vec[l] <= '0;
            end
            r_int_mask <= '0;
            r_vec_base <= '0;
            r_pending  <= '0;
            r_held     <= '0;
        end else if (advance) begin
            r_ext_lvl  <= n_ext_lvl;
            r_tmr_lvl  <= n_tmr_lvl;
            r_tmr_ctrl <= n_tmr_ctrl;
            r_lim_one  <= n_lim_one;
            r_lim_two  <= n_lim_two;
            r_tmr_cnt  <= n_tmr_cnt;
            r_lvl_vec  <= n_lvl_vec;
            r_int_mask <= n_int_mask;
            r_vec_base <= n_vec_base;
            r_pending  <= n_pending;
            r_held     <= n_held;
        end
    end

    // ---------------- assertions ----------------
    // acknowledged level is no longer held in the result
    a_ack_drops_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.mode == MODE_ACK |=> !r_out.irq_levels[$past(r_in.ack_level)])
        else $error("acknowledged level still held");

    // timers only fire on a tick
    a_fire_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.mode != MODE_TICK |=> r_out.timer_fired == '0)
        else $error("timer fired outside a tick");

    // vector only returned on acknowledge
    a_vec_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.mode != MODE_ACK |=> r_out.ack_vector == '0)
        else $error("vector returned outside an acknowledge");

    // reported levels track the held state
    a_levels_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out.irq_levels == r_held)
        else $error("result levels differ from held levels");

endmodule

FILE: bench/tic_result_checker.sv
// ============================================================================
// tic_result_checker
// Watches both channels of the timer and interrupt block. It keeps its own
// copy of the timers and the interrupt controller, predicts one result for
// each accepted request, and compares every accepted result against the
// oldest prediction.
// ============================================================================
module tic_result_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  tic_pkg::t_in_req  i_in,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  tic_pkg::t_out_req i_out,
    output int                o_fail_count,
    output int                o_results_owed
);
    import tic_pkg::*;

    localparam logic [7:0] VEC_BLOCK_MASK = 8'he0;

    // Mirror of the block's registers
    logic [15:0] ext_lvl  [MAX_EXT_LINES];
    logic [15:0] tmr_lvl  [MAX_TIMERS];
    logic [15:0] tmr_ctrl [MAX_TIMERS];
    logic [15:0] lim_one  [MAX_TIMERS];
    logic [15:0] lim_two  [MAX_TIMERS];
    logic [23:0] ticks_left [MAX_TIMERS];
    logic        line_pend [MAX_EXT_LINES];
    logic [15:0] mask_reg;
    logic [15:0] vec_base;
    logic [7:0]  lvl_vec  [8];
    logic        lvl_held [8];

    t_out_req owed_q [$];
    t_out_req want;
    int       fails = 0;
    int       shown = 0;
    int       k;

    function automatic logic [15:0] byte_merge(input logic [15:0] old_val,
                                               input logic [15:0] data,
                                               input logic [1:0]  be);
        logic [15:0] m;
        m = {{8{be[1]}}, {8{be[0]}}};
        return (old_val & ~m) | (data & m);
    endfunction

    function automatic logic [23:0] period_of(input int t);
        logic [15:0] c;
        logic [23:0] lim;
        logic [3:0]  sc;
        c   = tmr_ctrl[t];
        lim = '0;
        if (c[TC_LIMSEL_LSB +: 2] == LIMSEL_ONE) begin
            lim = {8'h00, lim_one[t]};
        end else if (c[TC_LIMSEL_LSB +: 2] == LIMSEL_TWO) begin
            lim = {8'h00, lim_two[t]};
        end
        sc = c[TC_PRESC_LSB +: 4];
        if (sc > PRESC_MAX) begin
            sc = PRESC_MAX;
        end
        if (c[TC_CLKSRC_LSB +: 2] != CLKSRC_SYS) begin
            return '0;
        end
        return lim << sc;
    endfunction

    // Stops the timer, then reloads it unless the stop bit is set; 1 when a start found a zero period
    function automatic logic restart_timer(input int t);
        logic [23:0] p;
        ticks_left[t] = '0;
        if (tmr_ctrl[t][TC_STOP_BIT]) begin
            return 1'b0;
        end
        p = period_of(t);
        if (p == '0) begin
            return 1'b1;
        end
        ticks_left[t] = p;
        return 1'b0;
    endfunction

    function automatic void raise_level(input logic [15:0] lvl_reg, input logic [7:0] vec);
        lvl_vec[lvl_reg[2:0]]  = vec;
        lvl_held[lvl_reg[2:0]] = 1'b1;
    endfunction

    function automatic t_out_req predict_result(input t_in_req r);
        t_out_req    res;
        logic [8:0]  off;
        logic [7:0]  base;
        int          t;
        res  = '0;
        off  = r.reg_offset;
        base = vec_base[7:0] & VEC_BLOCK_MASK;
        case (r.mode)
            MODE_WRITE: begin
                if (r.byte_enable != 2'b00) begin
                    if (off >= OFF_EXT_LVL && off < OFF_EXT_LVL + MAX_EXT_LINES) begin
                        t = off - OFF_EXT_LVL;
                        ext_lvl[t] = byte_merge(ext_lvl[t], r.write_data, r.byte_enable);
                    end else if (off >= OFF_TMR_LVL && off < OFF_TMR_LVL + MAX_TIMERS) begin
                        t = off - OFF_TMR_LVL;
                        tmr_lvl[t] = byte_merge(tmr_lvl[t], r.write_data, r.byte_enable);
                    end else if (off == OFF_INT_MASK) begin
                        mask_reg = byte_merge(mask_reg, r.write_data, r.byte_enable);
                    end else if (off == OFF_VEC_BASE) begin
                        vec_base = byte_merge(vec_base, r.write_data, r.byte_enable);
                    end else if (off[8:6] == OFF_TMR_PAGE && off[5:4] != 2'd3) begin
                        t = off[5:4];
                        if (off[3:0] == SUB_TMR_CTRL) begin
                            tmr_ctrl[t] = byte_merge(tmr_ctrl[t], r.write_data,
                                                     r.byte_enable);
                            // only a low-byte write restarts the timer
                            if (r.byte_enable[0]) begin
                                res.zero_period_error = restart_timer(t);
                            end
                        end else if (off[3:0] == SUB_LIMIT_ONE) begin
                            lim_one[t] = byte_merge(lim_one[t], r.write_data, r.byte_enable);
                        end else if (off[3:0] == SUB_LIMIT_TWO) begin
                            lim_two[t] = byte_merge(lim_two[t], r.write_data, r.byte_enable);
                        end
                    end
                end
            end
            MODE_EDGE: begin
                if (r.ext_line < MAX_EXT_LINES) begin
                    line_pend[r.ext_line] = 1'b1;
                    // masked lines keep their pending bit
                    for (t = 0; t < MAX_EXT_LINES; t++) begin
                        if (line_pend[t] && !mask_reg[t]) begin
                            raise_level(ext_lvl[t], base + 8'(t));
                            line_pend[t] = 1'b0;
                        end
                    end
                end
            end
            MODE_TICK: begin
                for (t = 0; t < MAX_TIMERS; t++) begin
                    if (ticks_left[t] != '0) begin
                        ticks_left[t] = ticks_left[t] - 24'd1;
                        if (ticks_left[t] == '0) begin
                            res.timer_fired[t] = 1'b1;
                            if (tmr_ctrl[t][TC_INT_EN_BIT] && !mask_reg[TMR_MASK_LSB + t]) begin
                                raise_level(tmr_lvl[t], base + 8'(TMR_VEC_OFS + t));
                            end
                            if (tmr_ctrl[t][TC_REPEAT_BIT]) begin
                                res.zero_period_error = res.zero_period_error
                                                        | restart_timer(t);
                            end
                        end
                    end
                end
            end
            default: begin
                res.ack_vector          = lvl_vec[r.ack_level];
                lvl_held[r.ack_level]   = 1'b0;
            end
        endcase
        for (t = 0; t < 8; t++) begin
            res.irq_levels[t] = lvl_held[t];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (k = 0; k < MAX_TIMERS; k++) begin
                tmr_lvl[k]    = '0;
                tmr_ctrl[k]   = '0;
                lim_one[k]    = '0;
                lim_two[k]    = '0;
                ticks_left[k] = '0;
            end
            for (k = 0; k < MAX_EXT_LINES; k++) begin
                ext_lvl[k]   = '0;
                line_pend[k] = 1'b0;
            end
            for (k = 0; k < 8; k++) begin
                lvl_vec[k]  = '0;
                lvl_held[k] = 1'b0;
            end
            mask_reg = '0;
            vec_base = '0;
            owed_q.delete();
        end else begin
            // result first: it belongs to an older request than this cycle's
            if (i_out_valid && !i_out_stall) begin
                if (owed_q.size() == 0) begin
                    fails++;
                    if (shown < 10) begin
                        $display("unexpected result: levels %h vector %h fired %b zp %b",
                                 i_out.irq_levels, i_out.ack_vector,
                                 i_out.timer_fired, i_out.zero_period_error);
                    end
                    shown++;
                end else begin
                    want = owed_q.pop_front();
                    if (want.irq_levels !== i_out.irq_levels ||
                        want.ack_vector !== i_out.ack_vector ||
                        want.timer_fired !== i_out.timer_fired ||
                        want.zero_period_error !== i_out.zero_period_error) begin
                        fails++;
                        if (shown < 10) begin
                            $display({"mismatch: levels exp %h got %h, vector exp %h got %h,",
                                      " fired exp %b got %b, zp exp %b got %b"},
                                     want.irq_levels, i_out.irq_levels,
                                     want.ack_vector, i_out.ack_vector,
                                     want.timer_fired, i_out.timer_fired,
                                     want.zero_period_error, i_out.zero_period_error);
                        end
                        shown++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                owed_q.push_back(predict_result(i_in));
            end
        end
        o_fail_count   = fails;
        o_results_owed = owed_q.size();
    end

endmodule

FILE: bench/timer_interrupt_controller_top_tb.sv
// ============================================================================
// timer_interrupt_controller_top_tb
// Drives requests into the timer and interrupt block under random idling on
// both channels; a side checker predicts and compares every result, and this
// module gives the verdict once all results are in.
// ============================================================================
module timer_interrupt_controller_top_tb;
    import tic_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;   // far above the slowest correct run
    localparam int RANDOM_ITEMS = 1920;
    localparam int CALM_FROM    = 1600;     // no idling from here to the end

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_req   i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_req  o_out;

    int        fail_count;
    int        results_owed;
    int        cycle_count = 0;
    logic      idle_on = 1'b1;     // enables random gaps and stalls
    int        stall_left = 0;

    always #6 i_clk = ~i_clk;

    timer_interrupt_controller_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    tic_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in           (i_in),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out          (o_out),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed)
    );

    // Watchdog: a hung handshake or a lost result ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result-side backpressure: random stall bursts, changed only
    // on the falling edge
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Request with every field random, so that ignored fields see both
    // values on every bit
    function automatic t_in_req noise_req(input t_mode m);
        t_in_req r;
        r.mode        = m;
        r.reg_offset  = 9'($urandom);
        r.write_data  = 16'($urandom);
        r.byte_enable = 2'($urandom);
        r.ext_line    = 2'($urandom);
        r.ack_level   = 3'($urandom);
        return r;
    endfunction

    function automatic logic [8:0] tmr_off(input int t, input logic [3:0] sub);
        return {OFF_TMR_PAGE, 2'(t), sub};
    endfunction

    function automatic logic [15:0] ctl_word(input logic int_en, input logic rpt,
                                             input logic [1:0] sel, input logic [3:0] presc,
                                             input logic [1:0] clk_src, input logic stop);
        logic [15:0] w;
        w = '0;
        w[TC_INT_EN_BIT]        = int_en;
        w[TC_REPEAT_BIT]        = rpt;
        w[TC_STOP_BIT]          = stop;
        w[TC_LIMSEL_LSB +: 2]   = sel;
        w[TC_PRESC_LSB +: 4]    = presc;
        w[TC_CLKSRC_LSB +: 2]   = clk_src;
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Valid stays high between back-to-back requests.
    task automatic send_req(input t_in_req r);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [8:0] off, input logic [15:0] data,
                             input logic [1:0] be);
        t_in_req r;
        r             = noise_req(MODE_WRITE);
        r.reg_offset  = off;
        r.write_data  = data;
        r.byte_enable = be;
        send_req(r);
    endtask

    task automatic line_edge(input logic [1:0] line);
        t_in_req r;
        r          = noise_req(MODE_EDGE);
        r.ext_line = line;
        send_req(r);
    endtask

    task automatic ack_level(input logic [2:0] lvl);
        t_in_req r;
        r           = noise_req(MODE_ACK);
        r.ack_level = lvl;
        send_req(r);
    endtask

    initial begin
        t_in_req     r;
        int          n;
        int          pick;
        int          t;
        logic [1:0]  be;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------- directed part ----------------
        // levels: line 0 -> 7 (upper bits ignored), line 1 -> 0, line 2 -> 3
        write_reg(OFF_EXT_LVL + 9'd0, 16'hfff7, 2'b11);
        write_reg(OFF_EXT_LVL + 9'd1, 16'h0000, 2'b11);
        write_reg(OFF_EXT_LVL + 9'd2, 16'h0003, 2'b01);
        // timers 0 and 1 share level 5, timer 2 sits on level 0
        write_reg(OFF_TMR_LVL + 9'd0, 16'h0005, 2'b11);
        write_reg(OFF_TMR_LVL + 9'd1, 16'h0005, 2'b11);
        write_reg(OFF_TMR_LVL + 9'd2, 16'h0000, 2'b11);
        write_reg(OFF_VEC_BASE, 16'hffff, 2'b11);
        write_reg(OFF_INT_MASK, 16'h0000, 2'b11);
        write_reg(tmr_off(0, SUB_LIMIT_ONE), 16'd2, 2'b11);
        write_reg(tmr_off(1, SUB_LIMIT_TWO), 16'd2, 2'b11);
        write_reg(tmr_off(2, SUB_LIMIT_ONE), 16'd0, 2'b11);
        // timer 0 repeating, timer 1 one-shot, timer 2 start with zero period
        write_reg(tmr_off(0, SUB_TMR_CTRL),
                  ctl_word(1'b1, 1'b1, LIMSEL_ONE, 4'd0, CLKSRC_SYS, 1'b0), 2'b01);
        write_reg(tmr_off(1, SUB_TMR_CTRL),
                  ctl_word(1'b1, 1'b0, LIMSEL_TWO, 4'd0, CLKSRC_SYS, 1'b0), 2'b11);
        write_reg(tmr_off(2, SUB_TMR_CTRL),
                  ctl_word(1'b1, 1'b0, LIMSEL_ONE, 4'd0, CLKSRC_SYS, 1'b0), 2'b11);
        // both expire on the same tick: timer 1's vector wins level 5
        repeat (2) send_req(noise_req(MODE_TICK));
        ack_level(3'd5);
        // limit drops to zero, so the repeat reload flags an error
        write_reg(tmr_off(0, SUB_LIMIT_ONE), 16'd0, 2'b11);
        repeat (2) send_req(noise_req(MODE_TICK));
        line_edge(2'd3);                           // absent line, ignored
        line_edge(2'd0);
        write_reg(OFF_INT_MASK, 16'h0002, 2'b01);  // mask line 1
        line_edge(2'd1);                           // stays pending
        line_edge(2'd2);
        ack_level(3'd6);                           // level never raised
        ack_level(3'd7);
        write_reg(OFF_INT_MASK, 16'hffff, 2'b00);  // no byte enabled
        write_reg(9'h1ff, 16'hffff, 2'b11);        // undecoded
        // high byte only: no restart even with max prescale
        write_reg(tmr_off(1, SUB_TMR_CTRL),
                  ctl_word(1'b1, 1'b1, LIMSEL_ONE, 4'hf, CLKSRC_SYS, 1'b0), 2'b10);
        write_reg(tmr_off(1, SUB_TMR_CTRL),
                  ctl_word(1'b1, 1'b1, LIMSEL_ONE, 4'd0, CLKSRC_SYS, 1'b1), 2'b11);
        write_reg(tmr_off(1, SUB_TMR_CTRL),
                  ctl_word(1'b1, 1'b1, LIMSEL_ONE, 4'd0, 2'd3, 1'b0), 2'b11);
        write_reg(OFF_INT_MASK, 16'h0000, 2'b11);  // unmask: line 1 waits for next edge

        // ---------------- random part ----------------
        // mostly ticks and timer programming with short periods, so timers
        // expire often; the rest writes levels, masks, odd offsets, edges
        // and acknowledges
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = (n < CALM_FROM) && !(n >= 700 && n < 900);
            r    = noise_req(MODE_TICK);
            pick = $urandom_range(0, 99);
            be   = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b11;
            if (pick < 25) begin
                r.mode        = MODE_WRITE;
                r.byte_enable = be;
                t             = $urandom_range(0, MAX_TIMERS - 1);
                pick          = $urandom_range(0, 99);
                if (pick < 35) begin
                    r.reg_offset = tmr_off(t, SUB_TMR_CTRL);
                    r.write_data = (16'($urandom) & 16'h0349) |
                                   ctl_word(($urandom_range(0, 3) != 0),
                                            ($urandom_range(0, 9) < 7),
                                            ($urandom_range(0, 4) == 0) ? 2'($urandom)
                                                : 2'($urandom_range(1, 2)),
                                            ($urandom_range(0, 4) == 0) ? 4'($urandom)
                                                : 4'($urandom_range(0, 1)),
                                            ($urandom_range(0, 7) == 0) ? 2'($urandom)
                                                : CLKSRC_SYS,
                                            ($urandom_range(0, 7) == 0));
                end else if (pick < 60) begin
                    r.reg_offset = tmr_off(t, $urandom_range(0, 1) ? SUB_LIMIT_ONE
                                                                  : SUB_LIMIT_TWO);
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        r.write_data = 16'($urandom_range(1, 6));
                    end else if (pick < 85) begin
                        r.write_data = 16'h0000;
                    end
                end else if (pick < 75) begin
                    r.reg_offset = $urandom_range(0, 1) ? OFF_EXT_LVL + 9'(t)
                                                        : OFF_TMR_LVL + 9'(t);
                end else if (pick < 85) begin
                    r.reg_offset = OFF_INT_MASK;
                end else if (pick < 90) begin
                    r.reg_offset = OFF_VEC_BASE;
                end
                // otherwise the random offset from the noise request stays
            end else if (pick < 40) begin
                r.mode = MODE_EDGE;
            end else if (pick < 55) begin
                r.mode = MODE_ACK;
            end
            send_req(r);
        end
        i_in_valid <= 1'b0;

        // drain, then wait quietly for any stray result
        while (results_owed != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/tic_pkg.sv
design/timer_interrupt_controller_top.sv
bench/tic_result_checker.sv
bench/timer_interrupt_controller_top_tb.sv
